// ===== src/ihc_pkg.sv =====
package ihc_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] VERDICT_FORWARD = 2'd0;
  localparam logic [1:0] VERDICT_SELF    = 2'd1;
  localparam logic [1:0] VERDICT_INVALID = 2'd2;
  localparam logic [1:0] VERDICT_EXPIRED = 2'd3;

  localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
  localparam logic [3:0]  MIN_IHL       = 4'd5;
  localparam logic [7:0]  VERSION_MASK  = 8'hF0;
  localparam logic [7:0]  VERSION_FOUR  = 8'h40;
  localparam logic [7:0]  IHL_MASK      = 8'h0F;
  localparam logic [15:0] TTL_ONE       = 16'h0100;

  // Classified header word handed from the front to the back
  typedef struct packed {
    logic        bad;
    logic        self_hit;
    logic [15:0] ttl_protocol;
    logic [15:0] header_checksum;
    logic [31:0] dest_address;
  } ihc_item_t;

  // Fold one carry bit back into a 16-bit ones'-complement sum
  function automatic logic [15:0] oc_fold(input logic [16:0] s);
    oc_fold = s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

// ===== src/ihc_front.sv =====
module ihc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       version_ihl_tos,
  input  logic [15:0]       tot_len,
  input  logic [15:0]       ident,
  input  logic [15:0]       flags_fragment,
  input  logic [15:0]       ttl_protocol,
  input  logic [15:0]       header_checksum,
  input  logic [31:0]       source_address,
  input  logic [31:0]       dest_address,
  input  logic [15:0]       link_length,
  output logic              item_valid,
  input  logic              item_ready,
  output ihc_pkg::ihc_item_t item
);
  import ihc_pkg::*;

  logic [31:0] own_address;
  logic        f_valid;
  ihc_item_t   f_item;
  ihc_item_t   item_next;
  logic [19:0] raw_sum;
  logic [16:0] sum1;
  logic [15:0] sum2;
  logic [7:0]  vbyte;
  logic [3:0]  ihl;
  logic        bad;

  always_comb begin
    raw_sum = {4'd0, version_ihl_tos} + {4'd0, tot_len} + {4'd0, ident}
            + {4'd0, flags_fragment} + {4'd0, ttl_protocol} + {4'd0, header_checksum}
            + {4'd0, source_address[31:16]} + {4'd0, source_address[15:0]}
            + {4'd0, dest_address[31:16]} + {4'd0, dest_address[15:0]};
    sum1  = {1'b0, raw_sum[15:0]} + {13'd0, raw_sum[19:16]};
    sum2  = oc_fold(sum1);
    vbyte = version_ihl_tos[15:8];
    ihl   = 4'(vbyte & IHL_MASK);
    bad   = (link_length < MIN_HDR_BYTES)
          || (sum2 != 16'hFFFF)
          || ((vbyte & VERSION_MASK) != VERSION_FOUR)
          || (ihl < MIN_IHL)
          || (tot_len < {10'd0, ihl, 2'b00})
          || (tot_len != link_length);
    item_next.bad             = bad;
    item_next.self_hit        = (dest_address == own_address);
    item_next.ttl_protocol    = ttl_protocol;
    item_next.header_checksum = header_checksum;
    item_next.dest_address    = dest_address;
  end

  assign in_ready   = !f_valid || item_ready;
  assign item_valid = f_valid;
  assign item       = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_address <= 32'd0;
    end else if (cfg_we) begin
      own_address <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_ready) begin
      f_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_item <= item_next;
    end
  end

endmodule

// ===== src/ihc_queue.sv =====
module ihc_queue #(
  parameter int DEPTH = ihc_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  ihc_pkg::ihc_item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output ihc_pkg::ihc_item_t pop_item
);
  import ihc_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ihc_item_t        slots [DEPTH];
  logic [IDX_W-1:0] wr_ptr;
  logic [IDX_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count missed a push");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (wr_ptr == rd_ptr))
    else $error("queue empty with pointers apart");
`endif

endmodule

// ===== src/ihc_back.sv =====
module ihc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  ihc_pkg::ihc_item_t item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         verdict,
  output logic [15:0]        new_ttl_protocol,
  output logic [15:0]        new_checksum,
  output logic [31:0]        next_hop_key
);
  import ihc_pkg::*;

  logic [1:0]  verdict_next;
  logic [15:0] ttl_next;
  logic [15:0] cks_next;
  logic [7:0]  ttl;

  always_comb begin
    ttl          = item.ttl_protocol[15:8];
    verdict_next = VERDICT_FORWARD;
    ttl_next     = item.ttl_protocol;
    cks_next     = item.header_checksum;
    if (item.bad) begin
      verdict_next = VERDICT_INVALID;
    end else if (item.self_hit) begin
      verdict_next = VERDICT_SELF;
    end else if (ttl[7:1] == 7'd0) begin
      verdict_next = VERDICT_EXPIRED;
    end else begin
      ttl_next = {ttl - 8'd1, item.ttl_protocol[7:0]};
      cks_next = oc_fold({1'b0, item.header_checksum} + {1'b0, TTL_ONE});
    end
  end

  // Load the output word when it is empty or being taken
  assign item_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (item_ready) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      verdict          <= verdict_next;
      new_ttl_protocol <= ttl_next;
      new_checksum     <= cks_next;
      next_hop_key     <= item.dest_address;
    end
  end

`ifndef SYNTH
  a_fwd_ttl: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && !item.bad && !item.self_hit && (ttl[7:1] != 7'd0))
    |=> (out_valid && verdict == VERDICT_FORWARD && new_ttl_protocol[15:8] != 8'd0))
    else $error("forwarded word with zero ttl");
  a_drop_keeps: assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready && item.bad)
    |=> (verdict == VERDICT_INVALID && new_ttl_protocol == $past(item.ttl_protocol)
         && new_checksum == $past(item.header_checksum)))
    else $error("invalid word altered fields");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready)
    |=> (out_valid && $stable(verdict) && $stable(new_ttl_protocol)
         && $stable(new_checksum) && $stable(next_hop_key)))
    else $error("output word changed while stalled");
`endif

endmodule

// ===== src/ipv4_header_check_ttl_update.sv =====
// A header word accepted on s_tdata passes the front check register, then a queue slot,
// then the output register, before it shows on m_tdata.
// Throughput: one header per cycle when not stalled; front check register, queue and
// output register each pass one word per cycle, and the queue absorbs output stalls.
// Reset (rst, synchronous): clears all valid flags, the queue and own_address to 0.
module ipv4_header_check_ttl_update #(
  parameter int QUEUE_DEPTH = ihc_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,    // own_address
  input  logic         s_tvalid,
  output logic         s_tready,
  // version_ihl_tos[15:0], tot_len[31:16], ident[47:32], flags_fragment[63:48],
  // ttl_protocol[79:64], header_checksum[95:80], source_address[127:96],
  // dest_address[159:128], link_length[175:160]
  input  logic [175:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // verdict[1:0], new_ttl_protocol[17:2], new_checksum[33:18],
  // next_hop_key[65:34], zero[71:66]
  output logic [71:0]  m_tdata
);
  import ihc_pkg::*;

  ihc_item_t   f_item;
  logic        f_valid;
  logic        f_ready;
  ihc_item_t   q_item;
  logic        q_valid;
  logic        q_ready;
  logic [1:0]  verdict;
  logic [15:0] new_ttl_protocol;
  logic [15:0] new_checksum;
  logic [31:0] next_hop_key;

  ihc_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (s_tvalid),
    .in_ready        (s_tready),
    .version_ihl_tos (s_tdata[15:0]),
    .tot_len         (s_tdata[31:16]),
    .ident           (s_tdata[47:32]),
    .flags_fragment  (s_tdata[63:48]),
    .ttl_protocol    (s_tdata[79:64]),
    .header_checksum (s_tdata[95:80]),
    .source_address  (s_tdata[127:96]),
    .dest_address    (s_tdata[159:128]),
    .link_length     (s_tdata[175:160]),
    .item_valid      (f_valid),
    .item_ready      (f_ready),
    .item            (f_item)
  );

  ihc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  ihc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (q_valid),
    .item_ready       (q_ready),
    .item             (q_item),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .verdict          (verdict),
    .new_ttl_protocol (new_ttl_protocol),
    .new_checksum     (new_checksum),
    .next_hop_key     (next_hop_key)
  );

  assign m_tdata = {6'd0, next_hop_key, new_checksum, new_ttl_protocol, verdict};

endmodule
